@@ rtl/core/wft_pkg.sv @@
// word frequency table package: status and function codes, sequencer states,
// byte classification helpers; no dependencies
package wft_pkg;

    localparam int ENTRIES_DEF    = 256;
    localparam int WORD_CHARS_DEF = 30;
    localparam int COUNT_W        = 32;

    typedef enum logic [1:0] {
        FN_TEXT  = 2'd0,
        FN_FLUSH = 2'd1,
        FN_READ  = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_NONE      = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_COUNTED   = 3'd2,
        ST_FULL      = 3'd3,
        ST_READ_OK   = 3'd4,
        ST_BAD_INDEX = 3'd5,
        ST_EMPTY     = 3'd6
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SEARCH = 5'b00010,
        S_READ   = 5'b00100,
        S_HIT    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    typedef struct packed {
        logic       push;
        logic [7:0] data;
        logic       clear;
    } t_buf_ctl;

    typedef struct packed {
        t_status              status;
        logic [7:0]           pos;
        logic [COUNT_W-1:0]   cnt;
        logic [63:0]          chunk;
        logic                 trunc;
    } t_result;

    function automatic logic is_sep(input logic [7:0] b);
        return b == 8'd0 || (b >= 8'd9 && b <= 8'd13) || b == 8'd32;
    endfunction

    function automatic logic is_punct(input logic [7:0] b);
        return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
               (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] b);
        return (b >= 8'd97 && b <= 8'd122) ? b - 8'd32 : b;
    endfunction

endpackage

@@ rtl/core/wft_if.sv @@
// handshake channels of the word frequency table: request and result
// depends on nothing
interface wft_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] text_byte;
    logic [7:0] entry_index;
    logic [1:0] chunk_select;
    modport source (output valid, func, text_byte, entry_index, chunk_select, input ready);
    modport sink   (input valid, func, text_byte, entry_index, chunk_select, output ready);
endinterface

interface wft_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [7:0]  entry_position;
    logic [31:0] entry_count;
    logic [63:0] word_chunk;
    logic [8:0]  distinct_words;
    logic        truncated;
    modport source (output valid, status, entry_position, entry_count, word_chunk,
                    distinct_words, truncated, input ready);
    modport sink   (input valid, status, entry_position, entry_count, word_chunk,
                    distinct_words, truncated, output ready);
endinterface

@@ rtl/core/word_frequency_table.sv @@
// Word frequency table. Text bytes build a word in a buffer; a separator or
// flush ends it and a sequencer walks the stored words one entry per cycle
// through the single read port of the word memory. An item that ends a word
// and misses is appended as a new entry, or reported full; one that matches
// passes S_HIT to raise its count. A read passes S_READ; other items go to
// S_DONE. A new item is taken only while idle; a finished result waits in
// the output register without blocking it, and a stalled result holds the
// sequencer in its last state until the output register frees.
// Depends on wft_pkg, wft_if, wft_ram and wft_word_buf.
module word_frequency_table #(
    parameter int ENTRIES    = wft_pkg::ENTRIES_DEF,
    parameter int WORD_CHARS = wft_pkg::WORD_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    wft_in_if.sink      i_in,
    wft_out_if.source   o_out
);
    localparam int AW = $clog2(ENTRIES);
    localparam int TW = $clog2(ENTRIES + 1);
    localparam int RW = 8 * WORD_CHARS;
    localparam int CW = wft_pkg::COUNT_W;

    wft_pkg::t_state    r_state, n_state;
    logic [TW-1:0]      r_total, n_total;
    logic [TW-1:0]      r_ptr, n_ptr;
    logic [AW-1:0]      r_chk_ptr, n_chk_ptr;
    logic               r_chk_vld, n_chk_vld;
    logic [AW-1:0]      r_idx, n_idx;
    logic [1:0]         r_chunk, n_chunk;
    wft_pkg::t_result   r_res, n_res;
    wft_pkg::t_result   r_out, n_out;
    logic [8:0]         r_out_total, n_out_total;
    logic               r_ov, n_ov;

    wft_pkg::t_buf_ctl  buf_ctl;
    logic [RW-1:0]      buf_word;
    logic               buf_empty;
    logic               buf_ovf;

    logic               re;
    logic [AW-1:0]      raddr;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [CW-1:0]      cnt_wdata;
    logic [RW-1:0]      word_rd;
    logic [CW-1:0]      cnt_rd;
    logic [CW-1:0]      cnt_inc;
    logic               accept;

    function automatic logic [63:0] slice_of(input logic [RW-1:0] row, input logic [1:0] c);
        logic [63:0] v;
        int          pos;
        v = '0;
        for (int k = 0; k < 8; k++) begin
            pos = 8 * int'(c) + k;
            if (pos < WORD_CHARS) begin
                v[8*k +: 8] = row[8*pos +: 8];
            end
        end
        return v;
    endfunction

    wft_word_buf #(.WORD_CHARS(WORD_CHARS)) u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (buf_ctl),
        .o_word     (buf_word),
        .o_empty    (buf_empty),
        .o_overflow (buf_ovf)
    );

    wft_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_word_mem (
        .i_clk   (i_clk),
        .i_we    (we && r_state == wft_pkg::S_SEARCH),
        .i_waddr (waddr),
        .i_wdata (buf_word),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (word_rd)
    );

    wft_ram #(.WIDTH(CW), .DEPTH(ENTRIES)) u_count_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (cnt_wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (cnt_rd)
    );

    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == wft_pkg::S_IDLE);
    assign cnt_inc  = (cnt_rd == '1) ? cnt_rd : cnt_rd + CW'(1);

    always_comb begin
        n_state     = r_state;
        n_total     = r_total;
        n_ptr       = r_ptr;
        n_chk_ptr   = r_chk_ptr;
        n_chk_vld   = r_chk_vld;
        n_idx       = r_idx;
        n_chunk     = r_chunk;
        n_res       = r_res;
        n_out       = r_out;
        n_out_total = r_out_total;
        n_ov        = r_ov;
        buf_ctl     = '0;
        re          = 1'b0;
        raddr       = r_ptr[AW-1:0];
        we          = 1'b0;
        waddr       = r_chk_ptr;
        cnt_wdata   = cnt_inc;

        if (r_ov && o_out.ready) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            wft_pkg::S_IDLE: begin
                if (accept) begin
                    n_chunk   = i_in.chunk_select;
                    n_res     = '0;
                    n_ptr     = '0;
                    n_chk_vld = 1'b0;
                    n_state   = wft_pkg::S_DONE;
                    if ((i_in.func == wft_pkg::FN_TEXT && wft_pkg::is_sep(i_in.text_byte))
                        || i_in.func == wft_pkg::FN_FLUSH) begin
                        if (buf_empty) begin
                            n_res.status  = wft_pkg::ST_EMPTY;
                            buf_ctl.clear = 1'b1;
                        end else begin
                            n_state = wft_pkg::S_SEARCH;
                        end
                    end else if (i_in.func == wft_pkg::FN_TEXT) begin
                        buf_ctl.push = !wft_pkg::is_punct(i_in.text_byte);
                        buf_ctl.data = wft_pkg::upcase(i_in.text_byte);
                    end else if (i_in.func == wft_pkg::FN_READ) begin
                        if ((TW + 8)'(i_in.entry_index) < (TW + 8)'(r_total)) begin
                            re      = 1'b1;
                            raddr   = AW'(i_in.entry_index);
                            n_idx   = AW'(i_in.entry_index);
                            n_state = wft_pkg::S_READ;
                        end else begin
                            n_res.status = wft_pkg::ST_BAD_INDEX;
                        end
                    end
                end
            end
            wft_pkg::S_SEARCH: begin
                if (r_chk_vld && word_rd == buf_word) begin
                    n_state = wft_pkg::S_HIT;
                end else if (r_ptr < r_total) begin
                    re        = 1'b1;
                    n_chk_ptr = r_ptr[AW-1:0];
                    n_chk_vld = 1'b1;
                    n_ptr     = r_ptr + TW'(1);
                end else begin
                    n_res.trunc   = buf_ovf;
                    buf_ctl.clear = 1'b1;
                    n_state       = wft_pkg::S_DONE;
                    if (r_total < TW'(ENTRIES)) begin
                        we           = 1'b1;
                        waddr        = r_total[AW-1:0];
                        cnt_wdata    = CW'(1);
                        n_total      = r_total + TW'(1);
                        n_res.status = wft_pkg::ST_INSERTED;
                        n_res.pos    = 8'(r_total);
                        n_res.cnt    = CW'(1);
                        n_res.chunk  = slice_of(buf_word, r_chunk);
                    end else begin
                        n_res.status = wft_pkg::ST_FULL;
                    end
                end
            end
            wft_pkg::S_HIT: begin
                we            = 1'b1;
                n_res.status  = wft_pkg::ST_COUNTED;
                n_res.pos     = 8'(r_chk_ptr);
                n_res.cnt     = cnt_inc;
                n_res.chunk   = slice_of(word_rd, r_chunk);
                n_res.trunc   = buf_ovf;
                buf_ctl.clear = 1'b1;
                n_state       = wft_pkg::S_DONE;
            end
            wft_pkg::S_READ: begin
                n_res.status = wft_pkg::ST_READ_OK;
                n_res.pos    = 8'(r_idx);
                n_res.cnt    = cnt_rd;
                n_res.chunk  = slice_of(word_rd, r_chunk);
                n_state      = wft_pkg::S_DONE;
            end
            wft_pkg::S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    n_out       = r_res;
                    n_out_total = 9'(r_total);
                    n_ov        = 1'b1;
                    n_state     = wft_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = wft_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= wft_pkg::S_IDLE;
            r_total   <= '0;
            r_ov      <= 1'b0;
            r_chk_vld <= 1'b0;
            r_ptr     <= '0;
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_ov      <= n_ov;
            r_chk_vld <= n_chk_vld;
            r_ptr     <= n_ptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_ptr   <= n_chk_ptr;
        r_idx       <= n_idx;
        r_chunk     <= n_chunk;
        r_res       <= n_res;
        r_out       <= n_out;
        r_out_total <= n_out_total;
    end

    assign o_out.valid          = r_ov;
    assign o_out.status         = r_out.status;
    assign o_out.entry_position = r_out.pos;
    assign o_out.entry_count    = r_out.cnt;
    assign o_out.word_chunk     = r_out.chunk;
    assign o_out.distinct_words = r_out_total;
    assign o_out.truncated      = r_out.trunc;

`ifndef SYNTHESIS
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= TW'(ENTRIES)) else $error("entry total beyond table size");
    a_ptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wft_pkg::S_SEARCH |-> r_ptr <= r_total)
        else $error("search pointer past filled entries");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != wft_pkg::S_IDLE)
        else $error("sequencer idle right after taking an item");
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total != $past(r_total) |-> r_state == wft_pkg::S_DONE)
        else $error("entry total changed outside an insert");
`endif
endmodule

@@ rtl/core/wft_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module wft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/wft_word_buf.sv @@
// word assembly buffer: appends bytes, flags overflow, clears on word end
// depends on wft_pkg
module wft_word_buf #(
    parameter int WORD_CHARS = wft_pkg::WORD_CHARS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  wft_pkg::t_buf_ctl       i_ctl,
    output logic [8*WORD_CHARS-1:0] o_word,
    output logic                    o_empty,
    output logic                    o_overflow
);
    localparam int LW = $clog2(WORD_CHARS + 1);

    logic [7:0]    r_buf [WORD_CHARS];
    logic [LW-1:0] r_len;
    logic          r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            for (int k = 0; k < WORD_CHARS; k++) begin
                r_buf[k] <= 8'd0;
            end
            r_len <= '0;
            r_ovf <= 1'b0;
        end else if (i_ctl.push) begin
            if (r_len < LW'(WORD_CHARS)) begin
                for (int k = 0; k < WORD_CHARS; k++) begin
                    if (r_len == LW'(k)) begin
                        r_buf[k] <= i_ctl.data;
                    end
                end
                r_len <= r_len + LW'(1);
            end else begin
                r_ovf <= 1'b1;
            end
        end
    end

    always_comb begin
        for (int k = 0; k < WORD_CHARS; k++) begin
            o_word[8*k +: 8] = r_buf[k];
        end
    end

    assign o_empty    = (r_len == '0);
    assign o_overflow = r_ovf;
endmodule
